>>> src/port_bitmap_allocator_top_macros.svh
// Assertion helpers. Each one samples on posedge clk and is off while arst_n is low.
`ifndef PORT_BITMAP_ALLOCATOR_TOP_MACROS_SVH
`define PORT_BITMAP_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication.
`define PBA_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PBA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/pba_pkg.sv
package pba_pkg;

	localparam int DEF_PORT_COUNT = 65536;
	localparam int DEF_WORD_BITS  = 32;

	localparam int PORT_W   = 16;
	localparam int MODE_W   = 2;
	localparam int STATUS_W = 2;

	localparam logic [PORT_W-1:0] ALLOC_BASE_RST = 16'hC000;

	localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CLAIM   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_IN_USE    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NONE_FREE = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic clr;
		logic take;
		logic div;
		logic setup;
		logic rmw;
		logic scan;
		logic alloc_wr;
		logic none;
		logic load_out;
	} pba_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic is_alloc;
		logic base_oob;
		logic found;
		logic exhausted;
		logic out_free;
	} pba_stat_t;

endpackage

>>> src/pba_ram.sv
module pba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/pba_ctrl.sv
module pba_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  pba_pkg::pba_stat_t  stat,
	output pba_pkg::pba_cmd_t   cmd
);

	typedef enum logic [2:0] {
		S_CLR,
		S_IDLE,
		S_DIV,
		S_SETUP,
		S_SCAN,
		S_AWR,
		S_RMW,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLR: begin
				cmd.clr = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div = 1'b1;
				state_d = S_SETUP;
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				if (!stat.is_alloc) begin
					state_d = S_RMW;
				end else if (stat.base_oob) begin
					state_d = S_DONE;
					cmd.none = 1'b1;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.found) begin
					state_d = S_AWR;
				end else if (stat.exhausted) begin
					cmd.none = 1'b1;
					state_d  = S_DONE;
				end
			end
			S_AWR: begin
				cmd.alloc_wr = 1'b1;
				state_d      = S_DONE;
			end
			S_RMW: begin
				cmd.rmw = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				// wait for room in the output register
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_ready = (state_q == S_IDLE);

endmodule

>>> src/pba_dp.sv
`include "port_bitmap_allocator_top_macros.svh"

module pba_dp #(
	parameter int PORT_COUNT = pba_pkg::DEF_PORT_COUNT,
	parameter int WORD_BITS  = pba_pkg::DEF_WORD_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pba_pkg::pba_cmd_t             cmd,
	output pba_pkg::pba_stat_t            stat,
	input  logic [pba_pkg::MODE_W-1:0]    in_mode,
	input  logic [pba_pkg::PORT_W-1:0]    in_port,
	input  logic                          cfg_we,
	input  logic [pba_pkg::PORT_W-1:0]    cfg_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pba_pkg::PORT_W-1:0]    out_port,
	output logic [pba_pkg::STATUS_W-1:0]  out_status
);

	localparam int PW         = pba_pkg::PORT_W;
	localparam int SW         = pba_pkg::STATUS_W;
	localparam int WORD_COUNT = (PORT_COUNT + WORD_BITS - 1) / WORD_BITS;
	localparam int WIDX       = WORD_COUNT > 1 ? $clog2(WORD_COUNT) : 1;
	localparam int SWW        = WIDX + 1;
	localparam int BIDX       = $clog2(WORD_BITS);
	localparam int RECIP_W    = 30;
	localparam int PROD_W     = PW + RECIP_W;

	// reciprocal of WORD_BITS scaled by 2^32, rounded up; exact for 16-bit dividends
	localparam longint unsigned RECIP_L =
		((64'd1 << 32) + longint'(WORD_BITS) - 64'd1) / longint'(WORD_BITS);
	localparam logic [RECIP_W-1:0] RECIP      = RECIP_W'(RECIP_L);
	localparam logic [PW:0]        PORT_LIMIT = (PW+1)'(PORT_COUNT);
	localparam logic [PW:0]        WCOUNT     = (PW+1)'(WORD_COUNT);
	localparam logic [SWW-1:0]     SCAN_END   = SWW'(WORD_COUNT);
	localparam logic [WIDX-1:0]    LAST_W     = WIDX'(WORD_COUNT - 1);

	logic [PW-1:0]        alloc_base_q;
	logic [WIDX-1:0]      clr_addr_q;
	logic                 chk_vld_q;
	logic                 out_vld_q;

	logic [pba_pkg::MODE_W-1:0] mode_q;
	logic [PW-1:0]        port_q;
	logic [PW-1:0]        q_q;
	logic [BIDX-1:0]      bit_q;
	logic [SWW-1:0]       scan_w_q;
	logic [WIDX-1:0]      chk_w_q;
	logic [WORD_BITS-1:0] old_word_q;
	logic [WORD_BITS-1:0] lowbit_q;
	logic [BIDX-1:0]      low_idx_q;
	logic [WIDX-1:0]      found_w_q;
	logic [PW-1:0]        res_port_q;
	logic [SW-1:0]        res_st_q;
	logic [PW-1:0]        out_port_q;
	logic [SW-1:0]        out_st_q;

	logic [PW-1:0]        div_in;
	logic [PROD_W-1:0]    prod;
	logic [PW-1:0]        q_next;
	logic [PW-1:0]        qmul;
	logic [PW-1:0]        rem_full;
	logic                 in_range;
	logic                 scan_issue;
	logic [WORD_BITS-1:0] rdata;
	logic [WORD_BITS-1:0] free_bits;
	logic [WORD_BITS-1:0] lowbit;
	logic [BIDX-1:0]      low_idx;
	logic [WORD_BITS-1:0] mask;
	logic                 used;
	logic [PW:0]          cand;
	logic                 ram_we;
	logic [WIDX-1:0]      ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic                 ram_re;
	logic [WIDX-1:0]      ram_raddr;
	logic [PW-1:0]        res_port_d;
	logic [SW-1:0]        res_st_d;

	// word index = operand / WORD_BITS by reciprocal multiply
	assign div_in   = (mode_q == pba_pkg::MODE_ALLOC) ? alloc_base_q : port_q;
	assign prod     = PROD_W'(div_in) * PROD_W'(RECIP);
	assign q_next   = PW'(prod >> 32);
	assign qmul     = PW'(q_q * WORD_BITS);
	assign rem_full = div_in - qmul;

	assign in_range = ({1'b0, port_q} < PORT_LIMIT);

	assign scan_issue = cmd.scan && (scan_w_q < SCAN_END);
	assign free_bits  = ~rdata;
	assign lowbit     = free_bits & (~free_bits + WORD_BITS'(1));

	always_comb begin
		low_idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (lowbit[i]) begin
				low_idx = low_idx | BIDX'(i);
			end
		end
	end

	assign mask = WORD_BITS'(1) << bit_q;
	assign used = (rdata & mask) != '0;
	assign cand = (PW+1)'(found_w_q * WORD_BITS) + (PW+1)'(low_idx_q);

	assign ram_re    = cmd.setup || scan_issue;
	assign ram_raddr = cmd.scan ? scan_w_q[WIDX-1:0] : q_q[WIDX-1:0];

	always_comb begin
		ram_we     = 1'b0;
		ram_waddr  = q_q[WIDX-1:0];
		ram_wdata  = rdata;
		res_port_d = port_q;
		res_st_d   = pba_pkg::STATUS_OK;
		if (cmd.clr) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else if (cmd.alloc_wr) begin
			ram_waddr = found_w_q;
			ram_wdata = old_word_q | lowbit_q;
			// lowest free bit past the last port: nothing left
			if (cand < PORT_LIMIT) begin
				ram_we     = 1'b1;
				res_port_d = cand[PW-1:0];
			end else begin
				res_port_d = '0;
				res_st_d   = pba_pkg::STATUS_NONE_FREE;
			end
		end else if (cmd.none) begin
			res_port_d = '0;
			res_st_d   = pba_pkg::STATUS_NONE_FREE;
		end else if (cmd.rmw) begin
			case (mode_q)
				pba_pkg::MODE_CLAIM: begin
					if (!in_range || used) begin
						res_st_d = pba_pkg::STATUS_IN_USE;
					end else begin
						ram_we    = 1'b1;
						ram_wdata = rdata | mask;
					end
				end
				pba_pkg::MODE_RELEASE: begin
					if (in_range) begin
						ram_we    = 1'b1;
						ram_wdata = rdata & ~mask;
					end
				end
				default: begin
					res_st_d = pba_pkg::STATUS_OK;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_base_q <= pba_pkg::ALLOC_BASE_RST;
			clr_addr_q   <= '0;
			chk_vld_q    <= 1'b0;
			out_vld_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				alloc_base_q <= cfg_data;
			end
			if (cmd.clr) begin
				clr_addr_q <= clr_addr_q + WIDX'(1);
			end
			if (cmd.setup) begin
				chk_vld_q <= 1'b0;
			end else if (cmd.scan) begin
				chk_vld_q <= scan_issue;
			end
			if (cmd.load_out) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mode_q <= in_mode;
			port_q <= in_port;
		end
		if (cmd.div) begin
			q_q <= q_next;
		end
		if (cmd.setup) begin
			bit_q    <= rem_full[BIDX-1:0];
			scan_w_q <= SWW'(q_q);
		end else if (scan_issue) begin
			scan_w_q <= scan_w_q + SWW'(1);
		end
		if (cmd.scan) begin
			chk_w_q <= scan_w_q[WIDX-1:0];
		end
		// hold the hit word; the read port keeps running ahead
		if (cmd.scan && stat.found) begin
			old_word_q <= rdata;
			lowbit_q   <= lowbit;
			low_idx_q  <= low_idx;
			found_w_q  <= chk_w_q;
		end
		if (cmd.rmw || cmd.alloc_wr || cmd.none) begin
			res_port_q <= res_port_d;
			res_st_q   <= res_st_d;
		end
		if (cmd.load_out) begin
			out_port_q <= res_port_q;
			out_st_q   <= res_st_q;
		end
	end

	pba_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (WORD_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	assign stat.clr_last  = (clr_addr_q == LAST_W);
	assign stat.is_alloc  = (mode_q == pba_pkg::MODE_ALLOC);
	assign stat.base_oob  = ({1'b0, q_q} >= WCOUNT);
	assign stat.found     = chk_vld_q && (free_bits != '0);
	assign stat.exhausted = chk_vld_q && (free_bits == '0) && (chk_w_q == LAST_W);
	assign stat.out_free  = !out_vld_q || out_ready;

	assign out_valid  = out_vld_q;
	assign out_port   = out_port_q;
	assign out_status = out_st_q;

	`PBA_ASSERT(a_alloc_one_bit, cmd.alloc_wr && ram_we, $countones(ram_wdata) == $countones(old_word_q) + 1, "allocate write must set exactly one new bit")
	`PBA_ASSERT(a_chk_in_range, chk_vld_q, (PW+1)'(chk_w_q) < WCOUNT, "scan checked a word beyond the bitmap")
	`PBA_ASSERT(a_load_free, cmd.load_out, !out_vld_q || out_ready, "result loaded over an untaken word")
	`PBA_ASSERT_NEXT(a_scan_restart, cmd.setup, !chk_vld_q, "scan pipeline not flushed at start")

endmodule

>>> src/port_bitmap_allocator_top.sv
// Channel   Dir  Handshake             Payload
// s_*       in   s_tvalid / s_tready   tdata: port[15:0]; tuser: mode[1:0]
// m_*       out  m_tvalid / m_tready   tdata: port_out[15:0]; tuser: status[1:0]
// cfg_*     in   cfg_valid / cfg_ready cfg_data: alloc_base[15:0]
//
// Claim, release and no-op pass DIV, SETUP and RMW to DONE; DONE loads the result when the
// output register is free. Allocate passes DIV and SETUP to SCAN, which reads bitmap words
// until a free bit (then AWR) or the last word, one word per cycle (up to 512 words at the
// default base). After reset a sweep zeroes the bitmap RAM (2048 words by default), one
// word per cycle; no word is accepted meanwhile, configuration writes are.
// A result waits in the output register; one more word is accepted and worked meanwhile.
module port_bitmap_allocator_top #(
	parameter int PORT_COUNT = pba_pkg::DEF_PORT_COUNT,
	parameter int WORD_BITS  = pba_pkg::DEF_WORD_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] port
	input  logic [1:0]  s_tuser,   // [1:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] port_out
	output logic [1:0]  m_tuser,   // [1:0] status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	pba_pkg::pba_cmd_t  cmd;
	pba_pkg::pba_stat_t stat;

	assign cfg_ready = 1'b1;

	pba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pba_dp #(
		.PORT_COUNT (PORT_COUNT),
		.WORD_BITS  (WORD_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_mode    (s_tuser),
		.in_port    (s_tdata),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_port   (m_tdata),
		.out_status (m_tuser)
	);

endmodule

>>> tb/pba_checker.sv
`timescale 1ns / 1ps

module pba_checker
	import pba_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [PORT_W-1:0]   s_tdata,   // [15:0] port
	input  logic [MODE_W-1:0]   s_tuser,   // [1:0] mode
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [PORT_W-1:0]   m_tdata,   // [15:0] port_out
	input  logic [STATUS_W-1:0] m_tuser,   // [1:0] status
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [PORT_W-1:0]   cfg_data,
	output int                  fail_cnt,
	output int                  outstanding,
	output int                  grants,
	output int                  none_free_cnt,
	output int                  in_use_cnt
);

	localparam int MAP_WORDS = DEF_PORT_COUNT / DEF_WORD_BITS;
	localparam int BIT_IDX_W = $clog2(DEF_WORD_BITS);

	typedef logic [DEF_WORD_BITS-1:0] map_word_t;

	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [PORT_W-1:0]   port_in;
		logic [PORT_W-1:0]   port_out;
		logic [STATUS_W-1:0] status;
	} port_answer_t;

	map_word_t         used_map [MAP_WORDS];
	logic [PORT_W-1:0] base_port;
	port_answer_t      expected_answers [$];
	int                accepted_cnt;
	int                returned_cnt;

	assign outstanding = accepted_cnt - returned_cnt;

	// Apply one request to the shadow bitmap and return the answer it must give.
	function automatic port_answer_t predict_port_op(input logic [MODE_W-1:0] mode,
			input logic [PORT_W-1:0] port);
		port_answer_t ans;
		int           w;
		int           b;
		bit           hit;
		ans.mode     = mode;
		ans.port_in  = port;
		ans.port_out = port;
		ans.status   = STATUS_OK;
		case (mode)
			MODE_ALLOC: begin
				hit          = 1'b0;
				ans.port_out = '0;
				ans.status   = STATUS_NONE_FREE;
				// low bits of the base below one word are ignored
				for (w = int'(base_port) / DEF_WORD_BITS; w < MAP_WORDS && !hit; w++) begin
					for (b = 0; b < DEF_WORD_BITS; b++) begin
						if (!used_map[w][b]) begin
							hit          = 1'b1;
							used_map[w][b] = 1'b1;
							ans.port_out = PORT_W'(w * DEF_WORD_BITS + b);
							ans.status   = STATUS_OK;
							break;
						end
					end
				end
			end
			MODE_CLAIM: begin
				if (used_map[port[PORT_W-1:BIT_IDX_W]][port[BIT_IDX_W-1:0]])
					ans.status = STATUS_IN_USE;
				else
					used_map[port[PORT_W-1:BIT_IDX_W]][port[BIT_IDX_W-1:0]] = 1'b1;
			end
			MODE_RELEASE: begin
				used_map[port[PORT_W-1:BIT_IDX_W]][port[BIT_IDX_W-1:0]] = 1'b0;
			end
			default: begin
				// unused mode: echo only
			end
		endcase
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		port_answer_t want;
		if (!arst_n) begin
			foreach (used_map[i])
				used_map[i] = '0;
			base_port = ALLOC_BASE_RST;
			expected_answers.delete();
			accepted_cnt  <= 0;
			returned_cnt  <= 0;
			fail_cnt      <= 0;
			grants        <= 0;
			none_free_cnt <= 0;
			in_use_cnt    <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				base_port = cfg_data;

			// retire the oldest answer before queuing a new one
			if (m_tvalid && m_tready) begin
				returned_cnt <= returned_cnt + 1;
				if (expected_answers.size() == 0) begin
					if (fail_cnt < 10)
						$display("unexpected result: port %h status %0d", m_tdata, m_tuser);
					fail_cnt <= fail_cnt + 1;
				end else begin
					want = expected_answers.pop_front();
					if (m_tdata !== want.port_out || m_tuser !== want.status) begin
						if (fail_cnt < 10)
							$display("mismatch: mode %0d port %h: expected port %h status %0d, got port %h status %0d",
								want.mode, want.port_in, want.port_out, want.status,
								m_tdata, m_tuser);
						fail_cnt <= fail_cnt + 1;
					end
					if (want.mode == MODE_ALLOC && want.status == STATUS_OK)
						grants <= grants + 1;
					if (want.status == STATUS_NONE_FREE)
						none_free_cnt <= none_free_cnt + 1;
					if (want.status == STATUS_IN_USE)
						in_use_cnt <= in_use_cnt + 1;
				end
			end

			if (s_tvalid && s_tready) begin
				expected_answers.push_back(predict_port_op(s_tuser, s_tdata));
				accepted_cnt <= accepted_cnt + 1;
			end
		end
	end

endmodule

>>> tb/tb_port_bitmap_allocator_top.sv
`timescale 1ns / 1ps

module tb_port_bitmap_allocator_top;
	import pba_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 600;
	localparam int PORT_WINDOW  = 96;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [PORT_W-1:0]   s_tdata;
	logic [MODE_W-1:0]   s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [PORT_W-1:0]   m_tdata;
	logic [STATUS_W-1:0] m_tuser;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [PORT_W-1:0]   cfg_data;

	int fail_cnt;
	int outstanding;
	int grants;
	int none_free_cnt;
	int in_use_cnt;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_req       = 0;
	int hold_ack       = 0;
	int items_sent     = 0;

	always #5 clk = ~clk;

	port_bitmap_allocator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	pba_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.fail_cnt      (fail_cnt),
		.outstanding   (outstanding),
		.grants        (grants),
		.none_free_cnt (none_free_cnt),
		.in_use_cnt    (in_use_cnt)
	);

	// Result side: random stalls, plus a long hold-off on request.
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_ack != hold_req) begin
				hold_ack = hold_req;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		#150_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Offer one word; return at the edge where it is taken.
	task automatic send_word(input logic [MODE_W-1:0] mode, input logic [PORT_W-1:0] port);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= PORT_W'($urandom);
			s_tuser  <= MODE_W'($urandom);
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= port;
		s_tuser  <= mode;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// Drain all pending answers, then write the base register.
	task automatic write_base(input logic [PORT_W-1:0] value);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_data  <= PORT_W'($urandom);
	endtask

	task automatic run_phase(input logic [PORT_W-1:0] base, input int idle_pct,
			input int stall_pct, input int count, input bit squeeze);
		logic [MODE_W-1:0] mode;
		logic [PORT_W-1:0] port;
		logic [PORT_W-1:0] win_start;
		int                r;
		write_base(base);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		win_start      = base & ~PORT_W'(DEF_WORD_BITS - 1);
		for (int i = 0; i < count; i++) begin
			if (squeeze && i == 10)
				hold_req++;
			r = $urandom_range(99);
			if (r < 40)
				mode = MODE_ALLOC;
			else if (r < 70)
				mode = MODE_CLAIM;
			else if (r < 95)
				mode = MODE_RELEASE;
			else
				mode = MODE_UNUSED;
			// mostly ports near the allocation window so claims collide and releases free
			if ($urandom_range(9) < 7)
				port = win_start + PORT_W'($urandom_range(PORT_WINDOW - 1));
			else
				port = PORT_W'($urandom);
			send_word(mode, port);
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset base
		send_word(MODE_ALLOC, 16'h0000);
		send_word(MODE_ALLOC, 16'hFFFF);
		send_word(MODE_CLAIM, 16'hC002);
		send_word(MODE_ALLOC, 16'h1234);
		send_word(MODE_CLAIM, 16'hC002);    // already taken
		send_word(MODE_RELEASE, 16'hC001);
		send_word(MODE_ALLOC, 16'h0000);    // reuses the hole
		send_word(MODE_RELEASE, 16'h0000);  // release of a port that is free
		send_word(MODE_CLAIM, 16'h0000);
		send_word(MODE_CLAIM, 16'hFFFF);
		send_word(MODE_CLAIM, 16'hFFFF);
		send_word(MODE_RELEASE, 16'hFFFF);
		send_word(MODE_UNUSED, 16'hA5A5);
		send_word(MODE_UNUSED, 16'h5A5A);
		send_word(MODE_CLAIM, 16'h5555);
		send_word(MODE_CLAIM, 16'hAAAA);
		send_word(MODE_RELEASE, 16'h5555);
		send_word(MODE_RELEASE, 16'hAAAA);

		run_phase(16'h0000, 0, 0, 190, 1'b0);
		run_phase(16'h1234, 81, 0, 190, 1'b0);  // unaligned base
		run_phase(16'hFFFF, 0, 81, 190, 1'b0);  // last word only, runs out often
		run_phase(16'hC000, 8, 8, 190, 1'b1);
		run_phase(PORT_W'($urandom), 81, 0, 190, 1'b0);
		run_phase(PORT_W'($urandom), 8, 8, 190, 1'b0);

		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests under six base settings and four idle patterns,",
			items_sent);
		$display("with one long output hold-off; %0d grants, %0d out-of-ports, %0d in-use.",
			grants, none_free_cnt, in_use_cnt);
		if (fail_cnt == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
